/* rtl/core/region_bump_allocator_unit_macros.svh */
// Assertion macros used by the region bump allocator controller
`ifndef REGION_BUMP_ALLOCATOR_UNIT_MACROS_SVH
`define REGION_BUMP_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst is high
`define RBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off while rst is high
`define RBA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/rba_pkg.sv */
// Shared types and constants for the region bump allocator
`default_nettype none

package rba_pkg;

  localparam int SIZE_W      = 16;
  localparam int CAP_W       = 13;
  localparam int LIMIT_W     = 4;
  localparam int MISS_W      = 4;
  localparam int STATUS_W    = 2;
  localparam int INDEX_W     = 4;
  localparam int ADDR_W      = 16;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CAP_W-1:0]   RESET_CAPACITY   = 13'd1024;
  localparam logic [LIMIT_W-1:0] RESET_SKIP_LIMIT = 4'd4;
  localparam logic [MISS_W-1:0]  MISS_MAX         = 4'd15;

  typedef enum logic [STATUS_W-1:0] {
    ST_EXISTING  = 2'd0,
    ST_NEW       = 2'd1,
    ST_TOO_BIG   = 2'd2,
    ST_NO_REGION = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CAPACITY   = 1'b0,
    CFG_SKIP_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } ctrl_state_t;

  // Search token that walks the row of region cells
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [INDEX_W-1:0] index;
    logic [ADDR_W-1:0]  base;        // index * capacity of the cell it enters
    logic [ADDR_W-1:0]  addr;        // placement address once found
    logic [ADDR_W-1:0]  fresh_addr;  // base address of the next unused region
  } probe_t;

  // Controller values for every cell; all but commit hold steady per transaction
  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic [CAP_W-1:0]   cap;
    logic [LIMIT_W-1:0] skip_limit;
    logic               commit;      // open next region, bump miss counters
  } bcast_t;

endpackage

`default_nettype wire

/* rtl/core/rba_cell.sv */
// One region cell: bump offset, miss counter and one hop of the search token
`default_nettype none

module rba_cell #(
  parameter int CELL_INDEX  = 0,
  parameter int IW          = 4,
  parameter int OW          = 5
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rba_pkg::bcast_t bcast,
  input  wire logic [IW-1:0]   search_start,
  input  wire logic [OW-1:0]   regions_open,
  input  wire rba_pkg::probe_t probe_in,
  input  wire logic [IW-1:0]   skip_in,
  output rba_pkg::probe_t      probe_out,
  output logic [IW-1:0]        skip_out
);
  import rba_pkg::*;

  localparam logic [OW-1:0] IDX      = OW'(CELL_INDEX);
  localparam logic [OW-1:0] IDX_NEXT = OW'(CELL_INDEX + 1);

  logic [CAP_W-1:0]  used;
  logic [MISS_W-1:0] miss;

  logic [SIZE_W:0]   sum;
  logic              in_range;
  logic              miss_range;
  logic              is_fresh;
  logic              claim;
  probe_t            probe_next;
  logic [IW-1:0]     skip_next;

  // Local decisions for this region
  always_comb begin
    sum        = (SIZE_W + 1)'(used) + (SIZE_W + 1)'(bcast.size);
    in_range   = (IDX >= OW'(search_start)) && (IDX < regions_open);
    miss_range = (IDX >= OW'(search_start)) && (IDX_NEXT < regions_open);
    is_fresh   = (IDX == regions_open);
    claim      = probe_in.valid && !probe_in.found && in_range &&
                 ((SIZE_W + 1)'(bcast.cap) > sum);
  end

  // Token update for the next hop
  always_comb begin
    probe_next      = probe_in;
    probe_next.base = probe_in.base + ADDR_W'(bcast.cap);
    skip_next       = skip_in;
    if (claim) begin
      probe_next.found = 1'b1;
      probe_next.index = INDEX_W'(CELL_INDEX);
      probe_next.addr  = probe_in.base + ADDR_W'(used);
    end
    if (is_fresh) begin
      probe_next.fresh_addr = probe_in.base;
    end
    // last qualifying region wins, so the start lands past the highest one
    if (miss_range && (miss > bcast.skip_limit)) begin
      skip_next = IW'(CELL_INDEX + 1);
    end
  end

  // Token register
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

  // Skip index travels beside the token
  always_ff @(posedge clk) begin
    skip_out <= skip_next;
  end

  // Region state
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      miss <= '0;
    end else if (bcast.commit && is_fresh) begin
      used <= bcast.size[CAP_W-1:0];
      miss <= '0;
    end else begin
      if (claim) begin
        used <= sum[CAP_W-1:0];
      end
      if (bcast.commit && miss_range && (miss != MISS_MAX)) begin
        miss <= miss + MISS_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rba_ctrl.sv */
// Controller: config registers, transaction sequencing, result register
`default_nettype none

`include "region_bump_allocator_unit_macros.svh"

module rba_ctrl #(
  parameter int NUM_REGIONS  = 16,
  parameter int MAX_CAPACITY = 4096,
  parameter int IW           = 4,
  parameter int OW           = 5
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [rba_pkg::SIZE_W-1:0]       request_size,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [rba_pkg::STATUS_W-1:0]          status,
  output logic [rba_pkg::INDEX_W-1:0]           region_index,
  output logic [rba_pkg::ADDR_W-1:0]            address,
  input  wire logic                             cfg_write,
  input  wire logic [rba_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [rba_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rba_pkg::bcast_t                       bcast,
  output logic [IW-1:0]                         search_start,
  output logic [OW-1:0]                         regions_open,
  output rba_pkg::probe_t                       probe_launch,
  output logic [IW-1:0]                         skip_launch,
  input  wire rba_pkg::probe_t                  probe_ret,
  input  wire logic [IW-1:0]                    skip_ret
);
  import rba_pkg::*;

  ctrl_state_t        state;
  ctrl_state_t        state_next;
  logic [CAP_W-1:0]   region_capacity;
  logic [LIMIT_W-1:0] skip_limit;
  logic [SIZE_W-1:0]  size_q;
  logic               launch;
  status_t            res_status;
  logic [INDEX_W-1:0] res_index;
  logic [ADDR_W-1:0]  res_addr;

  logic [CAP_W-1:0]   cap_eff;
  logic               accept;
  logic               too_big;
  logic               room;
  logic               ret_done;
  logic               commit;
  logic               out_free;

  // Effective capacity and request checks
  always_comb begin
    cap_eff  = ((CAP_W + 4)'(region_capacity) > (CAP_W + 4)'(MAX_CAPACITY)) ?
               CAP_W'(MAX_CAPACITY) : region_capacity;
    accept   = in_valid && !in_stall;
    too_big  = request_size >= SIZE_W'(cap_eff);
    room     = regions_open < OW'(NUM_REGIONS);
    ret_done = (state == S_SEARCH) && probe_ret.valid;
    commit   = ret_done && !probe_ret.found && room;
    out_free = !out_valid || !out_stall;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = too_big ? S_FINISH : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (probe_ret.valid) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs toward the input channel and the cell row
  always_comb begin
    in_stall                = (state != S_IDLE);
    bcast.size              = size_q;
    bcast.cap               = cap_eff;
    bcast.skip_limit        = skip_limit;
    bcast.commit            = commit;
    probe_launch.valid      = launch;
    probe_launch.found      = 1'b0;
    probe_launch.index      = '0;
    probe_launch.base       = '0;
    probe_launch.addr       = '0;
    probe_launch.fresh_addr = '0;
    skip_launch             = search_start;
  end

  // Control state and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      launch          <= 1'b0;
      search_start    <= '0;
      regions_open    <= OW'(1);
      region_capacity <= RESET_CAPACITY;
      skip_limit      <= RESET_SKIP_LIMIT;
      out_valid       <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept && !too_big;
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_CAPACITY:   region_capacity <= cfg_data;
          CFG_SKIP_LIMIT: skip_limit      <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        search_start <= skip_ret;
        regions_open <= regions_open + OW'(1);
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      size_q     <= request_size;
      res_status <= ST_TOO_BIG;
      res_index  <= '0;
      res_addr   <= '0;
    end else if (ret_done) begin
      if (probe_ret.found) begin
        res_status <= ST_EXISTING;
        res_index  <= probe_ret.index;
        res_addr   <= probe_ret.addr;
      end else if (!room) begin
        res_status <= ST_NO_REGION;
        res_index  <= '0;
        res_addr   <= '0;
      end else begin
        res_status <= ST_NEW;
        res_index  <= INDEX_W'(regions_open);
        res_addr   <= probe_ret.fresh_addr;
      end
    end
    if (state == S_FINISH && out_free) begin
      status       <= res_status;
      region_index <= res_index;
      address      <= res_addr;
    end
  end

  `RBA_ASSERT_IMP(a_ret_in_search, probe_ret.valid, state == S_SEARCH, "stray token")
  `RBA_ASSERT_IMP(a_commit_room, commit, room, "open with no region left")
  `RBA_ASSERT_IMP(a_start_open, 1'b1, OW'(search_start) < regions_open, "start past open")
  `RBA_ASSERT_NXT(a_too_big_skip, accept && too_big, state == S_FINISH && !launch, "oversize")

endmodule

`default_nettype wire

/* rtl/core/region_bump_allocator_unit.sv */
// Region bump allocator: controller plus a row of region cells
//
// Input channel: request_size with in_valid / in_stall; a transaction moves on a
// clock edge with in_valid high and in_stall low. Output channel: status,
// region_index and address with out_valid / out_stall, same rule.
// Config port: cfg_write with cfg_index (0 capacity, 1 skip limit) and cfg_data,
// taken on any edge with cfg_write high; write only while the block is idle.
// One result per request. A request at or above the capacity skips the search:
// the finish state loads its result straight into the output register. Any
// other request sends a search token down the row of NUM_REGIONS cells, one
// cell per cycle; the controller registers the returning token's outcome and
// the finish state then moves it into the output register. Misses, region
// opening and search start moves are applied together as the token returns.
// One request is in flight at a time; in_stall is high from acceptance until
// its result sits in the output register.
// A stalled result holds in the output register and the block waits.
// Synchronous reset empties the output, closes all regions but region 0,
// clears offsets and miss counters and restores capacity 1024, skip limit 4.
`default_nettype none

module region_bump_allocator_unit #(
  parameter int NUM_REGIONS  = 16,
  parameter int MAX_CAPACITY = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [rba_pkg::SIZE_W-1:0]       request_size,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [rba_pkg::STATUS_W-1:0]          status,
  output logic [rba_pkg::INDEX_W-1:0]           region_index,
  output logic [rba_pkg::ADDR_W-1:0]            address,
  input  wire logic                             cfg_write,
  input  wire logic [rba_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [rba_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rba_pkg::*;

  localparam int IW = $clog2(NUM_REGIONS);
  localparam int OW = $clog2(NUM_REGIONS + 1);

  bcast_t        bcast;
  logic [IW-1:0] search_start;
  logic [OW-1:0] regions_open;
  probe_t        probe_chain [NUM_REGIONS+1];
  logic [IW-1:0] skip_chain  [NUM_REGIONS+1];

  // Sequencer and result register
  rba_ctrl #(
    .NUM_REGIONS  (NUM_REGIONS),
    .MAX_CAPACITY (MAX_CAPACITY),
    .IW           (IW),
    .OW           (OW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .request_size (request_size),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .region_index (region_index),
    .address      (address),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .bcast        (bcast),
    .search_start (search_start),
    .regions_open (regions_open),
    .probe_launch (probe_chain[0]),
    .skip_launch  (skip_chain[0]),
    .probe_ret    (probe_chain[NUM_REGIONS]),
    .skip_ret     (skip_chain[NUM_REGIONS])
  );

  // Row of region cells, token moves one cell per cycle
  for (genvar g = 0; g < NUM_REGIONS; g++) begin : g_cell
    rba_cell #(
      .CELL_INDEX  (g),
      .IW          (IW),
      .OW          (OW)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .bcast        (bcast),
      .search_start (search_start),
      .regions_open (regions_open),
      .probe_in     (probe_chain[g]),
      .skip_in      (skip_chain[g]),
      .probe_out    (probe_chain[g+1]),
      .skip_out     (skip_chain[g+1])
    );
  end

endmodule

`default_nettype wire

/* tb/region_bump_allocator_unit_tb.sv */
// Self-checking testbench for the region bump allocator unit
`timescale 1ns / 1ps

module region_bump_allocator_unit_tb;
  import rba_pkg::*;

  localparam int REGIONS      = 16;
  localparam int MAX_CAP      = 4096;
  localparam int CLK_PERIOD   = 4;
  localparam int LATENCY      = REGIONS + 3;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_GAP      = 6;

  // One allocation result as seen on the output channel
  typedef struct packed {
    status_t              status;
    logic [INDEX_W-1:0]   index;
    logic [ADDR_W-1:0]    addr;
  } grant_t;

  // Request waiting to be offered; wait_drain holds it until all grants are back
  typedef struct {
    logic [SIZE_W-1:0] size;
    bit                wait_drain;
  } alloc_req_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [SIZE_W-1:0]      request_size = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [INDEX_W-1:0]     region_index;
  logic [ADDR_W-1:0]      address;
  logic                   cfg_write = 1'b0;
  cfg_reg_t               cfg_index = CFG_CAPACITY;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  region_bump_allocator_unit #(
    .NUM_REGIONS  (REGIONS),
    .MAX_CAPACITY (MAX_CAP)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .request_size (request_size),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .region_index (region_index),
    .address      (address),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Allocator mirror: settings and pool state
  logic [CAP_W-1:0]   cap_setting;
  logic [LIMIT_W-1:0] skip_setting;
  int                 region_used [REGIONS];
  int                 region_misses [REGIONS];
  int                 search_from;
  int                 open_regions;

  alloc_req_t   request_backlog [$];
  grant_t       expected_grants [$];
  bit           gaps_on = 1'b1;
  int           hold_requests = 0;
  int           holds_served = 0;
  int           mismatch_count = 0;
  int           sent_count = 0;
  int           settings_used = 0;
  int           status_tally [4];
  int           cycle_count = 0;

  // Work out the grant for one request and update the mirrored pool
  function automatic grant_t predict_grant(input logic [SIZE_W-1:0] size);
    grant_t g;
    int cap;
    int req;
    int r;
    int last;
    g.status = ST_TOO_BIG;
    g.index  = '0;
    g.addr   = '0;
    req = int'(size);
    cap = (int'(cap_setting) > MAX_CAP) ? MAX_CAP : int'(cap_setting);
    if (req >= cap) return g;
    // first open region from search_from with room strictly above the request
    for (r = search_from; r < open_regions && r < REGIONS; r++) begin
      if (cap > region_used[r] + req) begin
        g.status = ST_EXISTING;
        g.index  = INDEX_W'(r);
        g.addr   = ADDR_W'(r * cap + region_used[r]);
        region_used[r] += req;
        return g;
      end
    end
    if (open_regions >= REGIONS) begin
      g.status = ST_NO_REGION;
      return g;
    end
    // open the next region; misses on all searched but the last open one
    region_used[open_regions]   = req;
    region_misses[open_regions] = 0;
    last = open_regions - 1;
    for (r = search_from; r < last; r++) begin
      if (region_misses[r] > int'(skip_setting)) search_from = r + 1;
      if (region_misses[r] < int'(MISS_MAX)) region_misses[r]++;
    end
    g.status = ST_NEW;
    g.index  = INDEX_W'(open_regions);
    g.addr   = ADDR_W'(open_regions * cap);
    open_regions++;
    return g;
  endfunction

  // Size mix: tiny, anywhere below capacity, boundaries, full 16-bit range
  function automatic logic [SIZE_W-1:0] pick_size(input int cap);
    int eff;
    eff = (cap > MAX_CAP) ? MAX_CAP : cap;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SIZE_W'($urandom_range(0, 15));
      4, 5: return (eff > 1) ? SIZE_W'($urandom_range(0, eff - 1)) : '0;
      6: return (eff > 0) ? SIZE_W'(eff - 1) : '0;
      7: return SIZE_W'(eff + $urandom_range(0, 2));
      8: return SIZE_W'($urandom_range(0, eff / 4));
      default: return SIZE_W'($urandom());
    endcase
  endfunction

  // Request driver
  bit                 offering = 1'b0;
  int                 send_gap = 0;
  logic [SIZE_W-1:0]  offered_size = '0;
  alloc_req_t         next_req;

  always @(posedge clk) begin
    if (rst) begin
      offering = 1'b0;
      send_gap = 0;
      in_valid <= 1'b0;
      request_size <= '0;
    end else begin
      if (offering && !in_stall) begin
        expected_grants.push_back(predict_grant(offered_size));
        sent_count++;
        offering = 1'b0;
        send_gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      end else if (!offering && send_gap > 0) begin
        send_gap--;
      end
      if (!offering && send_gap == 0 && request_backlog.size() > 0) begin
        if (!(request_backlog[0].wait_drain && expected_grants.size() != 0)) begin
          next_req = request_backlog.pop_front();
          offered_size = next_req.size;
          offering = 1'b1;
        end
      end
      in_valid <= offering;
      request_size <= offered_size;
    end
  end

  // Result monitor and receiver stall
  int      recv_gap = 0;
  int      recv_hold = 0;
  grant_t  want;

  always @(posedge clk) begin
    if (rst) begin
      recv_gap = 0;
      recv_hold = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          $error("unexpected result: status %0d index %0d address %0d",
                 status, region_index, address);
          mismatch_count++;
        end else begin
          want = expected_grants.pop_front();
          status_tally[want.status]++;
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatch_count++;
          end
          if (region_index !== want.index) begin
            $error("region_index: expected %0d, got %0d", want.index, region_index);
            mismatch_count++;
          end
          if (address !== want.addr) begin
            $error("address: expected %0d, got %0d", want.addr, address);
            mismatch_count++;
          end
        end
        recv_gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      end else if (recv_gap > 0) begin
        recv_gap--;
      end
      // long hold-off so the block backs up and stalls its input
      if (holds_served < hold_requests) begin
        recv_hold = LONG_HOLD;
        holds_served++;
      end else if (recv_hold > 0) begin
        recv_hold--;
      end
      out_stall <= (recv_hold > 0) || (recv_gap > 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // Register write at one edge; mirror updated alongside
  task automatic write_reg(input cfg_reg_t idx, input int value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_CAPACITY) cap_setting = CAP_W'(value);
    else skip_setting = LIMIT_W'(value);
  endtask

  task automatic wait_idle();
    while (request_backlog.size() != 0 || in_valid || expected_grants.size() != 0)
      @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic push_req(input logic [SIZE_W-1:0] size);
    alloc_req_t req;
    req.size = size;
    req.wait_drain = 1'b0;
    request_backlog.push_back(req);
  endtask

  // One random phase under a fresh setting
  task automatic run_phase(input int cap, input int lim, input int count,
                           input bit calm, input bit long_hold, input bit mid_drain);
    alloc_req_t req;
    int i;
    wait_idle();
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_SKIP_LIMIT, lim);
    settings_used++;
    gaps_on = !calm;
    for (i = 0; i < count; i++) begin
      req.size = pick_size(cap);
      req.wait_drain = mid_drain && (i == count / 2);
      request_backlog.push_back(req);
    end
    if (long_hold) hold_requests++;
  endtask

  // Stimulus sequence
  initial begin
    cap_setting = RESET_CAPACITY;
    skip_setting = RESET_SKIP_LIMIT;
    for (int i = 0; i < REGIONS; i++) begin
      region_used[i] = 0;
      region_misses[i] = 0;
    end
    search_from = 0;
    open_regions = 1;
    for (int i = 0; i < 4; i++) status_tally[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: empty request, exact fit, capacity boundary, full range
    push_req(16'd0);
    push_req(16'd1023);
    push_req(16'd1024);
    push_req(16'hFFFF);
    push_req(16'd0);
    push_req(16'd1);
    push_req(16'd1023);
    push_req(16'h5555);
    push_req(16'hAAAA);
    settings_used++;

    // capacity above maximum clamps; zero skip limit moves the search start
    wait_idle();
    write_reg(CFG_CAPACITY, 8191);
    write_reg(CFG_SKIP_LIMIT, 0);
    push_req(16'd4095);
    push_req(16'd4096);
    push_req(16'd8191);
    settings_used++;

    // zero capacity refuses everything
    wait_idle();
    write_reg(CFG_CAPACITY, 0);
    push_req(16'd0);
    push_req(16'd1);

    // capacity shrunk below existing offsets, then tiny regions
    wait_idle();
    write_reg(CFG_CAPACITY, 1);
    push_req(16'd0);
    wait_idle();
    write_reg(CFG_CAPACITY, 2);
    write_reg(CFG_SKIP_LIMIT, 15);
    push_req(16'd1);
    push_req(16'd0);
    push_req(16'd2);
    settings_used += 3;

    // random phases over varied settings
    run_phase(4096, 0, 250, 1'b0, 1'b0, 1'b0);
    run_phase(300, 2, 200, 1'b1, 1'b0, 1'b0);
    run_phase(1024, 4, 200, 1'b0, 1'b1, 1'b0);
    run_phase(8191, 15, 150, 1'b0, 1'b0, 1'b1);
    run_phase(2, 14, 150, 1'b0, 1'b0, 1'b0);
    run_phase($urandom_range(2, MAX_CAP), $urandom_range(0, 14), 250, 1'b0, 1'b0, 1'b1);
    run_phase(0, 7, 50, 1'b1, 1'b0, 1'b0);
    run_phase(4096, 9, 250, 1'b0, 1'b1, 1'b0);
    run_phase(1, 3, 50, 1'b0, 1'b0, 1'b0);
    wait_idle();

    $display("covered %0d requests under %0d register settings", sent_count, settings_used);
    $display("grants: %0d existing, %0d new region, %0d too big, %0d out of regions",
             status_tally[ST_EXISTING], status_tally[ST_NEW],
             status_tally[ST_TOO_BIG], status_tally[ST_NO_REGION]);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* region_bump_allocator_unit.f */
+incdir+rtl/core
rtl/core/rba_pkg.sv
rtl/core/rba_cell.sv
rtl/core/rba_ctrl.sv
rtl/core/region_bump_allocator_unit.sv
tb/region_bump_allocator_unit_tb.sv
